/* hw/rtl/stdq_pkg.sv */
// shared types and constants of the software timer deadline queue
`default_nettype none

package stdq_pkg;

  // result kinds
  localparam logic [1:0] KIND_TIMEOUT = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;

  // configuration register indexes
  localparam logic [0:0] CFG_TASK_VALUE  = 1'b0;
  localparam logic [0:0] CFG_TASK_PERIOD = 1'b1;

  // request modes
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // reset values and fixed owner of a re-armed task timer
  localparam logic [31:0] TASK_VALUE_RST  = 32'h8000_0000;
  localparam logic [15:0] TASK_PERIOD_RST = 16'd2;
  localparam logic [63:0] TASK_OWNER      = 64'd1;

  // one stored timer, as held in the slot memory
  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] tag;
    logic [63:0] owner;
    logic [31:0] age;
  } slot_rec_t;

  localparam int unsigned REC_W = $bits(slot_rec_t);

  // commands from the controller to the datapath
  typedef struct packed {
    logic add;
    logic tick;
    logic scan_start;
    logic rearm;
    logic load_to;
    logic load_sum;
    logic load_full;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic has_free;
    logic scan_done;
    logic found;
    logic best_task;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/stdq_if.sv */
// request and result channel interfaces of the timer queue
`default_nettype none

interface stdq_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic        [63:0] deadline;
  logic signed [31:0] timer_tag;
  logic        [63:0] owner_id;

  modport source (output valid, mode, deadline, timer_tag, owner_id, input ready);
  modport sink   (input valid, mode, deadline, timer_tag, owner_id, output ready);
endinterface

interface stdq_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic        [63:0] expired_deadline;
  logic signed [31:0] expired_tag;
  logic        [63:0] expired_owner;
  logic               switch_task;
  logic               last;

  modport source (output valid, kind, expired_deadline, expired_tag, expired_owner,
                  switch_task, last, input ready);
  modport sink   (input valid, kind, expired_deadline, expired_tag, expired_owner,
                  switch_task, last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stdq_ram.sv */
// generic single write port, single read port ram with registered read
`default_nettype none

module stdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/stdq_dp.sv */
// timer queue datapath: slot memory, scan and select, counters, result register
`default_nettype none

module stdq_dp #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire stdq_pkg::dp_cmd_t  cmd,
  output stdq_pkg::dp_sts_t       sts,
  // request payload
  input  wire logic [63:0]        in_deadline,
  input  wire logic [31:0]        in_tag,
  input  wire logic [63:0]        in_owner,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // result register
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_kind,
  output logic [63:0]             out_deadline,
  output logic [31:0]             out_tag,
  output logic [63:0]             out_owner,
  output logic                    out_switch,
  output logic                    out_last
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

  // configuration registers
  logic [31:0] ttv_r;
  logic [15:0] period_r;

  // counters and per-slot flags
  logic [63:0]      tc_r;
  logic [31:0]      serial_r;
  logic [SLOTS-1:0] used_r;
  logic [SLOTS-1:0] due_r;
  logic             sw_r;

  // scan sequencing
  logic          scan_act_r;
  logic [AW-1:0] addr_r;
  logic          cmp_vld_r;
  logic [AW-1:0] cmp_idx_r;
  logic          first_r;

  // best candidate so far
  logic                best_found_r;
  logic [AW-1:0]       best_idx_r;
  stdq_pkg::slot_rec_t best_rec_r;
  logic [31:0]         best_key_r;

  // result register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [63:0] out_dl_r;
  logic [31:0] out_tag_r;
  logic [63:0] out_own_r;
  logic        out_sw_r;
  logic        out_last_r;

  // memory ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  stdq_pkg::slot_rec_t ram_wrec;
  logic [stdq_pkg::REC_W-1:0] ram_rdata;
  stdq_pkg::slot_rec_t rd_rec;

  logic [AW-1:0] free_idx;
  logic          has_free;
  logic          cand_due;
  logic [31:0]   cand_key;
  logic          cand_better;
  logic          best_task;
  logic          out_free;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    has_free = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = AW'(i);
        has_free = 1'b1;
      end
    end
  end

  // slot memory write: new timer or re-armed task timer
  always_comb begin
    ram_we    = cmd.add || cmd.rearm;
    ram_waddr = cmd.add ? free_idx : best_idx_r;
    if (cmd.add) begin
      ram_wrec.deadline = in_deadline;
      ram_wrec.tag      = in_tag;
      ram_wrec.owner    = in_owner;
    end else begin
      ram_wrec.deadline = tc_r + {48'd0, period_r};
      ram_wrec.tag      = best_rec_r.tag;
      ram_wrec.owner    = stdq_pkg::TASK_OWNER;
    end
    ram_wrec.age = serial_r;
  end

  stdq_ram #(
    .WIDTH (stdq_pkg::REC_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrec),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign rd_rec = stdq_pkg::slot_rec_t'(ram_rdata);

  // candidate test: due, then earliest deadline, then oldest insertion
  always_comb begin
    cand_due    = first_r ? (used_r[cmp_idx_r] && (rd_rec.deadline <= tc_r))
                          : due_r[cmp_idx_r];
    cand_key    = serial_r - rd_rec.age;
    cand_better = !best_found_r
               || (rd_rec.deadline < best_rec_r.deadline)
               || ((rd_rec.deadline == best_rec_r.deadline) && (cand_key > best_key_r));
  end

  assign best_task = (best_rec_r.tag == ttv_r);
  assign out_free  = !out_valid_r || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttv_r    <= stdq_pkg::TASK_VALUE_RST;
      period_r <= stdq_pkg::TASK_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        stdq_pkg::CFG_TASK_VALUE:  ttv_r    <= cfg_data;
        stdq_pkg::CFG_TASK_PERIOD: period_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // counters, flags and scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r         <= '0;
      serial_r     <= '0;
      used_r       <= '0;
      due_r        <= '0;
      sw_r         <= 1'b0;
      scan_act_r   <= 1'b0;
      addr_r       <= '0;
      cmp_vld_r    <= 1'b0;
      cmp_idx_r    <= '0;
      first_r      <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      if (cmd.tick) begin
        tc_r <= tc_r + 64'd1;
        sw_r <= 1'b0;
      end
      if (ram_we) begin
        serial_r <= serial_r + 32'd1;
      end
      if (cmd.add) begin
        used_r[free_idx] <= 1'b1;
      end
      if (cmd.rearm) begin
        due_r[best_idx_r] <= 1'b0;
        sw_r              <= 1'b1;
      end
      if (cmd.load_to) begin
        due_r[best_idx_r]  <= 1'b0;
        used_r[best_idx_r] <= 1'b0;
      end

      // address sweep over all slots
      cmp_vld_r <= scan_act_r;
      cmp_idx_r <= addr_r;
      if (cmd.scan_start) begin
        scan_act_r   <= 1'b1;
        addr_r       <= '0;
        first_r      <= cmd.tick;
        best_found_r <= 1'b0;
      end else if (scan_act_r) begin
        addr_r <= addr_r + AW'(1);
        if (addr_r == LAST_IDX) begin
          scan_act_r <= 1'b0;
        end
      end

      // compare stage, one slot a cycle
      if (cmp_vld_r) begin
        if (first_r) begin
          due_r[cmp_idx_r] <= cand_due;
        end
        if (cand_due && cand_better) begin
          best_found_r <= 1'b1;
        end
      end
    end
  end

  // best candidate payload
  always_ff @(posedge clk) begin
    if (cmp_vld_r && cand_due && cand_better) begin
      best_idx_r <= cmp_idx_r;
      best_rec_r <= rd_rec;
      best_key_r <= cand_key;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_to || cmd.load_sum || cmd.load_full) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_to) begin
      out_kind_r <= stdq_pkg::KIND_TIMEOUT;
      out_dl_r   <= best_rec_r.deadline;
      out_tag_r  <= best_rec_r.tag;
      out_own_r  <= best_rec_r.owner;
      out_sw_r   <= 1'b0;
      out_last_r <= 1'b0;
    end else if (cmd.load_sum || cmd.load_full) begin
      out_kind_r <= cmd.load_sum ? stdq_pkg::KIND_SUMMARY : stdq_pkg::KIND_FULL;
      out_dl_r   <= '0;
      out_tag_r  <= '0;
      out_own_r  <= '0;
      out_sw_r   <= cmd.load_sum ? sw_r : 1'b0;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_deadline = out_dl_r;
  assign out_tag      = out_tag_r;
  assign out_owner    = out_own_r;
  assign out_switch   = out_sw_r;
  assign out_last     = out_last_r;

  // status to the controller
  always_comb begin
    sts.has_free  = has_free;
    sts.scan_done = cmp_vld_r && (cmp_idx_r == LAST_IDX);
    sts.found     = best_found_r;
    sts.best_task = best_task;
    sts.out_free  = out_free;
  end

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_to || cmd.load_sum || cmd.load_full) |-> out_free)
    else $error("result register loaded while a result is still pending");

  a_add_to_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add |-> (has_free && !used_r[free_idx]))
    else $error("timer added to an occupied slot");

  a_rearm_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rearm |-> (best_found_r && best_task && due_r[best_idx_r]))
    else $error("re-arm without a due task timer selected");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_act_r || cmp_vld_r) |-> !ram_we)
    else $error("slot memory written during a scan");

  a_timeout_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_to |=> !used_r[$past(best_idx_r)])
    else $error("expired timer still holds its slot");

endmodule

`default_nettype wire

/* hw/rtl/stdq_ctrl.sv */
// timer queue controller: request handling and tick sequencing
`default_nettype none

module stdq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_mode,
  output logic                   in_ready,
  input  wire stdq_pkg::dp_sts_t sts,
  output stdq_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT_TO,
    ST_EMIT_SUM,
    ST_EMIT_FULL
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == stdq_pkg::MODE_TICK) begin
            cmd.tick       = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else if (sts.has_free) begin
            cmd.add = 1'b1;
          end else begin
            state_nxt = ST_EMIT_FULL;
          end
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!sts.found) begin
          state_nxt = ST_EMIT_SUM;
        end else if (sts.best_task) begin
          cmd.rearm      = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end else begin
          state_nxt = ST_EMIT_TO;
        end
      end
      ST_EMIT_TO: begin
        if (sts.out_free) begin
          cmd.load_to    = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_EMIT_SUM: begin
        if (sts.out_free) begin
          cmd.load_sum = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_EMIT_FULL: begin
        if (sts.out_free) begin
          cmd.load_full = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/software_timer_deadline_queue.sv */
// Software timer deadline queue: holds up to SLOTS pending timers (deadline, tag, owner)
// and a 64-bit tick counter. An add request is written to a free slot as it is taken;
// when no slot is free the full result is loaded into the result register once that
// register is free. A tick request runs one selection pass per expired timer plus a
// final empty pass; each pass sweeps every slot through the single read port of the
// slot memory, and a timeout result waits for the result register to be free. One
// request is handled at a time; the result register lets the next request in while
// the final result waits to be taken.
`default_nettype none

module software_timer_deadline_queue #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  stdq_in_if.sink          in_if,
  stdq_out_if.source       out_if,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  stdq_pkg::dp_cmd_t cmd;
  stdq_pkg::dp_sts_t sts;
  logic [31:0]       out_tag;

  // request sequencing
  stdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_mode  (in_if.mode),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, selection and result register
  stdq_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_deadline  (in_if.deadline),
    .in_tag       (in_if.timer_tag),
    .in_owner     (in_if.owner_id),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .out_kind     (out_if.kind),
    .out_deadline (out_if.expired_deadline),
    .out_tag      (out_tag),
    .out_owner    (out_if.expired_owner),
    .out_switch   (out_if.switch_task),
    .out_last     (out_if.last)
  );

  assign out_if.expired_tag = $signed(out_tag);

endmodule

`default_nettype wire

/* tb/software_timer_deadline_queue_test.sv */
// self-checking test of the software timer deadline queue: directed and random requests
`timescale 1ns / 100ps

module software_timer_deadline_queue_test;
  import stdq_pkg::*;

  localparam int SLOTS      = 16;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 40;
  localparam int SQUEEZE    = 400;

  typedef struct packed {
    logic        mode;
    logic [63:0] deadline;
    logic [31:0] tag;
    logic [63:0] owner;
  } timer_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] deadline;
    logic [31:0] tag;
    logic [63:0] owner;
    logic        switch_task;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;

  stdq_in_if  in_ch ();
  stdq_out_if out_ch ();

  software_timer_deadline_queue #(.SLOTS(SLOTS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // shadow copy of the timer store and its registers
  logic [31:0] sh_task_value;
  logic [15:0] sh_task_period;
  logic [63:0] sh_ticks;
  logic [63:0] sh_deadline [SLOTS];
  logic [31:0] sh_tag [SLOTS];
  logic [63:0] sh_owner [SLOTS];
  logic [31:0] sh_age [SLOTS];
  bit          sh_used [SLOTS];
  logic [31:0] sh_serial;

  timer_req_t    requests_to_send [$];
  timer_result_t timer_results_owed [$];
  timer_req_t    req_on_bus;

  int          mismatch_count = 0;
  int          results_seen = 0;
  bit          calm = 1'b0;
  logic [63:0] planned_ticks = 64'd0;

  // slot a is retired before slot b
  function automatic bit retires_first(input int a, input int b);
    if (sh_deadline[a] != sh_deadline[b])
      return sh_deadline[a] < sh_deadline[b];
    return (sh_serial - sh_age[a]) > (sh_serial - sh_age[b]);
  endfunction

  // apply one request to the shadow store and record the results it owes
  function automatic void apply_timer_request(input timer_req_t r);
    bit due [SLOTS];
    bit switched;
    bit placed;
    int best;
    int i;
    switched = 1'b0;
    placed = 1'b0;
    if (r.mode == MODE_ADD) begin
      for (i = 0; i < SLOTS; i++) begin
        if (!placed && !sh_used[i]) begin
          placed = 1'b1;
          sh_used[i] = 1'b1;
          sh_deadline[i] = r.deadline;
          sh_tag[i] = r.tag;
          sh_owner[i] = r.owner;
          sh_age[i] = sh_serial;
          sh_serial = sh_serial + 32'd1;
        end
      end
      if (!placed)
        timer_results_owed.insert(timer_results_owed.size(),
                                  '{KIND_FULL, 64'd0, 32'd0, 64'd0, 1'b0, 1'b1});
    end else begin
      sh_ticks = sh_ticks + 64'd1;
      for (i = 0; i < SLOTS; i++)
        due[i] = sh_used[i] && (sh_deadline[i] <= sh_ticks);
      do begin
        best = -1;
        for (i = 0; i < SLOTS; i++)
          if (due[i] && (best < 0 || retires_first(i, best)))
            best = i;
        if (best >= 0) begin
          due[best] = 1'b0;
          if (sh_tag[best] == sh_task_value) begin
            // task-switch timer goes round again
            switched = 1'b1;
            sh_deadline[best] = sh_ticks + {48'd0, sh_task_period};
            sh_owner[best] = TASK_OWNER;
            sh_age[best] = sh_serial;
            sh_serial = sh_serial + 32'd1;
          end else begin
            timer_results_owed.insert(timer_results_owed.size(),
                                      '{KIND_TIMEOUT, sh_deadline[best], sh_tag[best],
                                        sh_owner[best], 1'b0, 1'b0});
            sh_used[best] = 1'b0;
          end
        end
      end while (best >= 0);
      timer_results_owed.insert(timer_results_owed.size(),
                                '{KIND_SUMMARY, 64'd0, 32'd0, 64'd0, switched, 1'b1});
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void push_add(input logic [63:0] dl, input logic [31:0] tag,
                                   input logic [63:0] owner);
    requests_to_send.insert(requests_to_send.size(), '{MODE_ADD, dl, tag, owner});
  endfunction

  // tick fields are ignored by the block, so they carry junk
  function automatic void push_tick();
    requests_to_send.insert(requests_to_send.size(),
                            '{MODE_TICK, {$urandom, $urandom}, $urandom,
                              {$urandom, $urandom}});
    planned_ticks = planned_ticks + 64'd1;
  endfunction

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TASK_VALUE)
      sh_task_value = data;
    else
      sh_task_period = data[15:0];
  endtask

  // block idle: nothing left to send, nothing owed, then a settling tail
  task automatic wait_idle();
    do @(negedge clk);
    while (requests_to_send.size() != 0 || in_ch.valid || timer_results_owed.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // request driver
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        apply_timer_request(req_on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 13);
          in_ch.valid <= 1'b0;
        end else if (requests_to_send.size() > 0) begin
          req_on_bus = requests_to_send.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= req_on_bus.mode;
          in_ch.deadline <= req_on_bus.deadline;
          in_ch.timer_tag <= req_on_bus.tag;
          in_ch.owner_id <= req_on_bus.owner;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  int  stall_left = 0;
  int  squeeze_left = 0;
  bit  squeezed = 1'b0;
  always @(posedge clk) begin
    timer_result_t owed;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (timer_results_owed.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d", $time,
                   out_ch.kind);
          mismatch_count++;
        end else begin
          owed = timer_results_owed.pop_front();
          check_field("kind", {62'd0, owed.kind}, {62'd0, out_ch.kind});
          check_field("expired_deadline", owed.deadline, out_ch.expired_deadline);
          check_field("expired_tag", {32'd0, owed.tag}, {32'd0, out_ch.expired_tag});
          check_field("expired_owner", owed.owner, out_ch.expired_owner);
          check_field("switch_task", {63'd0, owed.switch_task}, {63'd0, out_ch.switch_task});
          check_field("last", {63'd0, owed.last}, {63'd0, out_ch.last});
        end
      end
      // one long hold-off so the block backs up into the request side
      if (squeeze_left > 0) begin
        squeeze_left--;
        out_ch.ready <= 1'b0;
      end else if (!squeezed && results_seen >= 60) begin
        squeezed = 1'b1;
        squeeze_left = SQUEEZE - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int          p;
    int          i;
    int          k;
    int          t;
    int          j;
    int          r;
    logic [31:0] v;
    logic [15:0] per;
    logic [63:0] dl;
    logic [31:0] tag;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TASK_VALUE;
    cfg_data = 32'd0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ADD;
    in_ch.deadline = 64'd0;
    in_ch.timer_tag = 32'sd0;
    in_ch.owner_id = 64'd0;
    out_ch.ready = 1'b0;

    sh_task_value = TASK_VALUE_RST;
    sh_task_period = TASK_PERIOD_RST;
    sh_ticks = 64'd0;
    sh_serial = 32'd0;
    for (i = 0; i < SLOTS; i++) begin
      sh_used[i] = 1'b0;
      sh_deadline[i] = 64'd0;
      sh_tag[i] = 32'd0;
      sh_owner[i] = 64'd0;
      sh_age[i] = 32'd0;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: task timer at reset value, zero and all-ones fields, ties
    push_add(64'd1, TASK_VALUE_RST, 64'hFFFF_FFFF_FFFF_FFFF);
    push_add(64'd0, 32'h7FFF_FFFF, 64'd0);
    push_add(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, {$urandom, $urandom});
    push_add(64'd3, 32'd0, {$urandom, $urandom});
    push_add(64'd2, $urandom, {$urandom, $urandom});
    push_add(64'd2, $urandom, {$urandom, $urandom});
    // first tick re-arms the task timer, third ties it with an ordinary one
    push_tick();
    push_tick();
    push_tick();
    // fill the free slots, then one more add that is dropped
    for (i = 0; i < 15; i++)
      push_add(64'd4, $urandom, {$urandom, $urandom});
    // retire fourteen timers sharing one deadline
    push_tick();
    wait_idle();

    // random phases, each under its own register setting
    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin
          v = 32'h7FFF_FFFF;
          per = 16'd1;
        end
        1: begin
          v = 32'd0;
          per = 16'($urandom_range(1, 4));
        end
        2: begin
          v = $urandom;
          per = 16'($urandom_range(1, 6));
        end
        3: begin
          v = TASK_VALUE_RST;
          per = 16'd3;
        end
        default: begin
          v = $urandom;
          per = 16'hFFFF;
          calm = 1'b1;
        end
      endcase
      write_reg(CFG_TASK_VALUE, v);
      write_reg(CFG_TASK_PERIOD, {16'($urandom), per});

      // rounds of adds followed by a few ticks; some rounds overfill the store
      j = 0;
      while (j < 18) begin
        k = ($urandom_range(0, 9) == 0) ? 18 : $urandom_range(0, 6);
        for (i = 0; i < k; i++) begin
          r = $urandom_range(0, 39);
          if (r == 0)
            dl = 64'd0;
          else if (r == 1)
            dl = {$urandom, $urandom};
          else
            dl = planned_ticks + 64'($urandom_range(0, 6));
          tag = ($urandom_range(0, 7) == 0) ? v : $urandom;
          push_add(dl, tag, {$urandom, $urandom});
        end
        t = $urandom_range(1, 3);
        for (i = 0; i < t; i++)
          push_tick();
        j += k + t;
      end
      wait_idle();
    end

    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
